// File: src/axfr_pkg.sv
package axfr_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MY_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [6:0] ADDR_MASK = 7'h7F;
  localparam logic [7:0] HDR_BYTES = 8'd3;

  localparam logic [2:0] STATUS_OK = 3'd0;
  localparam logic [2:0] STATUS_CSUM_ERR = 3'd1;
  localparam logic [2:0] STATUS_TO_LENGTH = 3'd2;
  localparam logic [2:0] STATUS_TO_COMMAND = 3'd3;
  localparam logic [2:0] STATUS_TO_TAIL = 3'd4;
  localparam logic [2:0] STATUS_TOO_LONG = 3'd5;

endpackage

// File: src/addressed_xor_frame_receiver_unit.sv
// Order: a status result caused by an accepted byte or tick transaction is registered
// and shown on the output the cycle after acceptance. The first payload result of a run
// follows a RAM read and then an output load, which waits while the output is held.
// Throughput: one input transaction per cycle while no payload run is active and the output
// is free; a payload run reads and loads its results one at a time and holds input off.
// Reset: control state and out_valid go to their reset values; the result data registers
// and the payload RAM are not cleared, a run only reads entries written by the same frame.
module addressed_xor_frame_receiver_unit #(
  parameter int unsigned PAYLOAD_MAX = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                mode_i,
  input  logic [7:0]                          rx_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [2:0]                          status_o,
  output logic                                is_read_o,
  output logic [7:0]                          command_o,
  output logic [4:0]                          byte_index_o,
  output logic [7:0]                          payload_byte_o,
  output logic                                byte_valid_o,
  output logic                                last_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [axfr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [axfr_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
  localparam logic [7:0] LEN_MAX = 8'(PAYLOAD_MAX + 4);
  localparam logic [5:0] STORE_MAX = 6'(PAYLOAD_MAX);

  typedef enum logic [1:0] {
    P_ADDR,
    P_LENGTH,
    P_COMMAND,
    P_TAIL
  } phase_e;

  typedef enum logic [1:0] {
    S_IN,
    S_RD,
    S_LD
  } state_e;

  state_e      state_q, state_d;
  phase_e      phase_q, phase_d;
  logic [6:0]  my_addr_q, my_addr_d;
  logic [15:0] timeout_q, timeout_d;
  logic        read_flag_q, read_flag_d;
  logic [7:0]  frame_len_q, frame_len_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  xor_q, xor_d;
  logic [5:0]  tail_cnt_q, tail_cnt_d;
  logic [15:0] idle_q, idle_d;
  logic [5:0]  plen_q, plen_d;
  logic [5:0]  rd_idx_q, rd_idx_d;

  logic        out_valid_q, out_valid_d;
  logic [2:0]  out_status_q, out_status_d;
  logic        out_read_q, out_read_d;
  logic [7:0]  out_cmd_q, out_cmd_d;
  logic [4:0]  out_idx_q, out_idx_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_bvalid_q, out_bvalid_d;
  logic        out_last_q, out_last_d;

  logic          in_acc;
  logic          out_free;
  logic [15:0]   limit;
  logic [15:0]   idle_inc;
  logic [7:0]    tail_total;
  logic [5:0]    plen_new;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_re;
  logic [7:0]    ram_rdata;
  logic          run_last;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IN) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign limit      = (timeout_q == 16'd0) ? 16'd1 : timeout_q;
  assign idle_inc   = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
  assign tail_total = (frame_len_q > axfr_pkg::HDR_BYTES) ? frame_len_q - axfr_pkg::HDR_BYTES
                                                          : 8'd0;
  assign plen_new   = (tail_total > 8'd0) ? 6'(tail_total - 8'd1) : 6'd0;
  assign ram_waddr  = tail_cnt_q[AW-1:0];
  assign run_last   = (rd_idx_q + 6'd1) == plen_q;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    my_addr_d   = my_addr_q;
    timeout_d   = timeout_q;
    read_flag_d = read_flag_q;
    frame_len_d = frame_len_q;
    cmd_d       = cmd_q;
    xor_d       = xor_q;
    tail_cnt_d  = tail_cnt_q;
    idle_d      = idle_q;
    plen_d      = plen_q;
    rd_idx_d    = rd_idx_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_read_d   = out_read_q;
    out_cmd_d    = out_cmd_q;
    out_idx_d    = out_idx_q;
    out_byte_d   = out_byte_q;
    out_bvalid_d = out_bvalid_q;
    out_last_d   = out_last_q;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        axfr_pkg::CFG_MY_ADDRESS:    my_addr_d = cfg_data_i[6:0];
        axfr_pkg::CFG_TIMEOUT_TICKS: timeout_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      S_IN: begin
        if (in_acc) begin
          // default shape of a single status result
          out_read_d   = read_flag_q;
          out_cmd_d    = cmd_q;
          out_idx_d    = 5'd0;
          out_byte_d   = 8'd0;
          out_bvalid_d = 1'b0;
          out_last_d   = 1'b1;
          if (mode_i) begin
            if (phase_q != P_ADDR) begin
              if (idle_inc >= limit) begin
                out_valid_d = 1'b1;
                case (phase_q)
                  P_LENGTH:  out_status_d = axfr_pkg::STATUS_TO_LENGTH;
                  P_COMMAND: out_status_d = axfr_pkg::STATUS_TO_COMMAND;
                  default:   out_status_d = axfr_pkg::STATUS_TO_TAIL;
                endcase
                phase_d = P_ADDR;
                idle_d  = 16'd0;
              end else begin
                idle_d = idle_inc;
              end
            end
          end else begin
            idle_d = 16'd0;
            case (phase_q)
              P_ADDR: begin
                if ((rx_byte_i[6:0] & axfr_pkg::ADDR_MASK) == my_addr_q) begin
                  read_flag_d = rx_byte_i[7];
                  xor_d       = rx_byte_i;
                  cmd_d       = 8'd0;
                  frame_len_d = 8'd0;
                  tail_cnt_d  = 6'd0;
                  phase_d     = P_LENGTH;
                end
              end
              P_LENGTH: begin
                frame_len_d = rx_byte_i;
                xor_d       = xor_q ^ rx_byte_i;
                if (rx_byte_i > LEN_MAX) begin
                  out_valid_d  = 1'b1;
                  out_status_d = axfr_pkg::STATUS_TOO_LONG;
                  out_cmd_d    = 8'd0;
                  phase_d      = P_ADDR;
                end else begin
                  phase_d = P_COMMAND;
                end
              end
              P_COMMAND: begin
                cmd_d      = rx_byte_i;
                xor_d      = xor_q ^ rx_byte_i;
                tail_cnt_d = 6'd0;
                if (tail_total == 8'd0) begin
                  phase_d      = P_ADDR;
                  out_valid_d  = 1'b1;
                  out_cmd_d    = rx_byte_i;
                  out_status_d = (xor_d != 8'd0) ? axfr_pkg::STATUS_CSUM_ERR
                                                 : axfr_pkg::STATUS_OK;
                end else begin
                  phase_d = P_TAIL;
                end
              end
              default: begin
                xor_d      = xor_q ^ rx_byte_i;
                ram_we     = tail_cnt_q < STORE_MAX;
                tail_cnt_d = tail_cnt_q + 6'd1;
                if ({2'b00, tail_cnt_d} >= tail_total) begin
                  phase_d = P_ADDR;
                  if (xor_d != 8'd0) begin
                    out_valid_d  = 1'b1;
                    out_status_d = axfr_pkg::STATUS_CSUM_ERR;
                  end else if (plen_new == 6'd0) begin
                    out_valid_d  = 1'b1;
                    out_status_d = axfr_pkg::STATUS_OK;
                  end else begin
                    plen_d   = plen_new;
                    rd_idx_d = 6'd0;
                    state_d  = S_RD;
                  end
                end
              end
            endcase
          end
        end
      end
      S_RD: begin
        ram_re  = 1'b1;
        state_d = S_LD;
      end
      S_LD: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = axfr_pkg::STATUS_OK;
          out_read_d   = read_flag_q;
          out_cmd_d    = cmd_q;
          out_idx_d    = rd_idx_q[4:0];
          out_byte_d   = ram_rdata;
          out_bvalid_d = 1'b1;
          out_last_d   = run_last;
          rd_idx_d     = rd_idx_q + 6'd1;
          state_d      = run_last ? S_IN : S_RD;
        end
      end
      default: state_d = S_IN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IN;
      phase_q     <= P_ADDR;
      my_addr_q   <= 7'd0;
      timeout_q   <= axfr_pkg::TIMEOUT_RESET;
      read_flag_q <= 1'b0;
      frame_len_q <= 8'd0;
      cmd_q       <= 8'd0;
      xor_q       <= 8'd0;
      tail_cnt_q  <= 6'd0;
      idle_q      <= 16'd0;
      plen_q      <= 6'd0;
      rd_idx_q    <= 6'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      my_addr_q   <= my_addr_d;
      timeout_q   <= timeout_d;
      read_flag_q <= read_flag_d;
      frame_len_q <= frame_len_d;
      cmd_q       <= cmd_d;
      xor_q       <= xor_d;
      tail_cnt_q  <= tail_cnt_d;
      idle_q      <= idle_d;
      plen_q      <= plen_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_read_q   <= out_read_d;
    out_cmd_q    <= out_cmd_d;
    out_idx_q    <= out_idx_d;
    out_byte_q   <= out_byte_d;
    out_bvalid_q <= out_bvalid_d;
    out_last_q   <= out_last_d;
  end

  axfr_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_MAX)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (rx_byte_i),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign is_read_o      = out_read_q;
  assign command_o      = out_cmd_q;
  assign byte_index_o   = out_idx_q;
  assign payload_byte_o = out_byte_q;
  assign byte_valid_o   = out_bvalid_q;
  assign last_o         = out_last_q;

  a_bvalid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_bvalid_q |-> out_status_q == axfr_pkg::STATUS_OK)
    else $error("payload result with non-ok status");

  a_no_write_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == S_IN)
    else $error("payload write during read-out run");

  a_idle_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == P_ADDR |-> idle_q == 16'd0)
    else $error("idle count nonzero while awaiting address");

  a_run_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IN |-> rd_idx_q < plen_q)
    else $error("read-out index beyond payload length");

endmodule

// File: src/axfr_ram.sv
module axfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: tb/tb_addressed_xor_frame_receiver_unit.sv
module tb_addressed_xor_frame_receiver_unit;

  localparam int unsigned PAYLOAD_MAX = 32;
  localparam int unsigned MAX_GAP = 17;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS = 28;
  localparam int unsigned NUM_PHASES = 5;
  localparam int unsigned DIR_ROWS = 25;
  localparam int unsigned TICK_BURST_MAX = 40;
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [1:0] {WAIT_ADDR, WAIT_LEN, WAIT_CMD, WAIT_TAIL} rx_phase_e;

  typedef struct packed {
    logic [2:0] status;
    logic       is_read;
    logic [7:0] command;
    logic [4:0] byte_index;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       last;
  } frame_result_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] data;
    logic       typed;
    logic [2:0] status;
    logic       is_read;
    logic [7:0] command;
  } step_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_mode = 1'b0;
  logic [7:0]                      in_byte = '0;
  logic                            out_ready = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic [axfr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [axfr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic       in_ready_o;
  logic       out_valid_o;
  logic       cfg_ready_o;
  logic [2:0] status_o;
  logic       is_read_o;
  logic [7:0] command_o;
  logic [4:0] byte_index_o;
  logic [7:0] payload_byte_o;
  logic       byte_valid_o;
  logic       last_o;

  addressed_xor_frame_receiver_unit #(
    .PAYLOAD_MAX(PAYLOAD_MAX)
  ) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .mode_i         (in_mode),
    .rx_byte_i      (in_byte),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .status_o       (status_o),
    .is_read_o      (is_read_o),
    .command_o      (command_o),
    .byte_index_o   (byte_index_o),
    .payload_byte_o (payload_byte_o),
    .byte_valid_o   (byte_valid_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // frame receiver predictor state
  logic [6:0]  my_addr = '0;
  logic [15:0] to_ticks = axfr_pkg::TIMEOUT_RESET;
  rx_phase_e   ph = WAIT_ADDR;
  logic        rd_flag = 1'b0;
  logic [7:0]  flen = '0;
  logic [7:0]  cmd_q = '0;
  logic [7:0]  xor_acc = '0;
  logic [5:0]  tcount = '0;
  logic [15:0] idle_cnt = '0;
  logic [7:0]  pstore [PAYLOAD_MAX];
  int unsigned model_out_count = 0;

  frame_result_t expected_results[$];
  step_row_t     directed_rows [DIR_ROWS];
  int unsigned   fail_count = 0;
  int unsigned   items_sent = 0;
  int unsigned   idle_cycles = 0;
  bit            fast_mode = 1'b0;
  bit            hold_req = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int unsigned tail_bytes();
    return (flen > axfr_pkg::HDR_BYTES) ? int'(flen - axfr_pkg::HDR_BYTES) : 0;
  endfunction

  task automatic emit_result(input logic [2:0] st, input logic [7:0] cmd,
                             input logic [4:0] idx, input logic [7:0] pb,
                             input logic vld, input logic lst);
    frame_result_t r;
    r = '{st, rd_flag, cmd, idx, pb, vld, lst};
    expected_results.push_back(r);
    model_out_count++;
  endtask

  task automatic close_frame();
    int unsigned plen;
    int unsigned i;
    plen = (tail_bytes() > 0) ? tail_bytes() - 1 : 0;
    ph = WAIT_ADDR;
    if (xor_acc != 8'h00) begin
      emit_result(axfr_pkg::STATUS_CSUM_ERR, cmd_q, 5'd0, 8'h00, 1'b0, 1'b1);
    end else if (plen == 0) begin
      emit_result(axfr_pkg::STATUS_OK, cmd_q, 5'd0, 8'h00, 1'b0, 1'b1);
    end else begin
      for (i = 0; i < plen && i < PAYLOAD_MAX; i++) begin
        emit_result(axfr_pkg::STATUS_OK, cmd_q, i[4:0], pstore[i[4:0]], 1'b1,
                    (i + 1 == plen));
      end
    end
  endtask

  task automatic advance_frame_model(input logic mode, input logic [7:0] b);
    logic [15:0] limit;
    model_out_count = 0;
    if (mode == MODE_TICK) begin
      limit = (to_ticks != 16'd0) ? to_ticks : 16'd1;
      if (ph != WAIT_ADDR) begin
        if (idle_cnt != 16'hFFFF) idle_cnt++;
        if (idle_cnt >= limit) begin
          case (ph)
            WAIT_LEN:
              emit_result(axfr_pkg::STATUS_TO_LENGTH, cmd_q, 5'd0, 8'h00, 1'b0, 1'b1);
            WAIT_CMD:
              emit_result(axfr_pkg::STATUS_TO_COMMAND, cmd_q, 5'd0, 8'h00, 1'b0, 1'b1);
            default:
              emit_result(axfr_pkg::STATUS_TO_TAIL, cmd_q, 5'd0, 8'h00, 1'b0, 1'b1);
          endcase
          ph = WAIT_ADDR;
          idle_cnt = '0;
        end
      end
    end else begin
      idle_cnt = '0;
      case (ph)
        WAIT_ADDR: begin
          if ((b[6:0] & axfr_pkg::ADDR_MASK) == my_addr) begin
            rd_flag = b[7];
            xor_acc = b;
            cmd_q = '0;
            flen = '0;
            tcount = '0;
            ph = WAIT_LEN;
          end
        end
        WAIT_LEN: begin
          flen = b;
          xor_acc ^= b;
          if (b > PAYLOAD_MAX + 4) begin
            emit_result(axfr_pkg::STATUS_TOO_LONG, 8'h00, 5'd0, 8'h00, 1'b0, 1'b1);
            ph = WAIT_ADDR;
          end else begin
            ph = WAIT_CMD;
          end
        end
        WAIT_CMD: begin
          cmd_q = b;
          xor_acc ^= b;
          tcount = '0;
          if (tail_bytes() == 0) close_frame();
          else ph = WAIT_TAIL;
        end
        default: begin
          xor_acc ^= b;
          if (tcount < PAYLOAD_MAX) pstore[tcount[4:0]] = b;
          tcount = tcount + 6'd1;
          if (tcount >= tail_bytes()) close_frame();
        end
      endcase
    end
  endtask

  task automatic send_item(input logic mode, input logic [7:0] b);
    int unsigned gap;
    gap = fast_mode ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_byte <= b;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    advance_frame_model(mode, b);
    items_sent++;
  endtask

  task automatic write_reg(input logic [axfr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [axfr_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    if (idx == axfr_pkg::CFG_MY_ADDRESS) my_addr = data[6:0];
    else if (idx == axfr_pkg::CFG_TIMEOUT_TICKS) to_ticks = data;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_good_frame(input bit corrupt);
    logic [7:0]  fbytes[$];
    logic [7:0]  len;
    logic [7:0]  chk;
    logic        rw;
    int unsigned sel;
    int unsigned ntail;
    int unsigned j;
    sel = $urandom_range(0, 9);
    if (sel < 6) len = 8'($urandom_range(0, 8));
    else if (sel < 9) len = 8'($urandom_range(9, 20));
    else len = 8'(PAYLOAD_MAX + 4);
    rw = 1'($urandom_range(0, 1));
    fbytes.push_back({rw, my_addr});
    fbytes.push_back(len);
    ntail = (len > axfr_pkg::HDR_BYTES) ? int'(len - axfr_pkg::HDR_BYTES) : 0;
    if (ntail == 0) begin
      fbytes.push_back(fbytes[0] ^ fbytes[1]);
    end else begin
      // command byte, then the tail bytes with the checksum last
      repeat (ntail + 1) fbytes.push_back(8'($urandom));
      chk = '0;
      for (j = 0; j + 1 < fbytes.size(); j++) chk ^= fbytes[j];
      fbytes[fbytes.size() - 1] = chk;
    end
    if (corrupt) begin
      j = $urandom_range(2, fbytes.size() - 1);
      fbytes[j] = fbytes[j] ^ (8'h01 << $urandom_range(0, 7));
    end
    for (j = 0; j < fbytes.size(); j++) begin
      send_item(MODE_BYTE, fbytes[j]);
      if (j + 1 < fbytes.size() && $urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 3)) send_item(MODE_TICK, 8'($urandom));
      end
    end
  endtask

  task automatic send_abort_frame();
    int unsigned stage;
    int unsigned ntail;
    int unsigned nticks;
    logic [7:0]  len;
    logic        rw;
    stage = $urandom_range(1, 3);
    rw = 1'($urandom_range(0, 1));
    send_item(MODE_BYTE, {rw, my_addr});
    if (stage >= 2) begin
      len = 8'($urandom_range(4, PAYLOAD_MAX + 4));
      send_item(MODE_BYTE, len);
      if (stage == 3) begin
        send_item(MODE_BYTE, 8'($urandom));
        ntail = int'(len - axfr_pkg::HDR_BYTES);
        repeat ($urandom_range(0, ntail - 1)) send_item(MODE_BYTE, 8'($urandom));
      end
    end
    nticks = (to_ticks <= TICK_BURST_MAX) ? int'(to_ticks) : $urandom_range(1, 5);
    repeat (nticks) send_item(MODE_TICK, 8'($urandom));
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int unsigned stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = fast_mode ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid_o) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (rst_n && out_valid_o && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d command %0h", status_o, command_o);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_count++;
        end
        if (is_read_o !== want.is_read) begin
          $error("is_read: expected %0d, got %0d", want.is_read, is_read_o);
          fail_count++;
        end
        if (command_o !== want.command) begin
          $error("command: expected %0h, got %0h", want.command, command_o);
          fail_count++;
        end
        if (byte_index_o !== want.byte_index) begin
          $error("byte_index: expected %0d, got %0d", want.byte_index, byte_index_o);
          fail_count++;
        end
        if (payload_byte_o !== want.payload_byte) begin
          $error("payload_byte: expected %0h, got %0h", want.payload_byte, payload_byte_o);
          fail_count++;
        end
        if (byte_valid_o !== want.byte_valid) begin
          $error("byte_valid: expected %0d, got %0d", want.byte_valid, byte_valid_o);
          fail_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (cfg_valid && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    frame_result_t   typed_res;
    int unsigned     r;
    int unsigned     p;
    int unsigned     kind;
    logic [6:0]      addr_val;
    logic [15:0]     to_val;
    logic [15:0]     addr_word;

    directed_rows = '{
      '{MODE_TICK, 8'hFF, 1'b0, axfr_pkg::STATUS_OK,       1'b0, 8'h00},
      '{MODE_BYTE, 8'h05, 1'b0, axfr_pkg::STATUS_OK,       1'b0, 8'h00},
      '{MODE_BYTE, 8'h80, 1'b0, axfr_pkg::STATUS_OK,       1'b0, 8'h00},
      '{MODE_BYTE, 8'hFF, 1'b1, axfr_pkg::STATUS_TOO_LONG, 1'b1, 8'h00},
      '{MODE_BYTE, 8'h00, 1'b0, axfr_pkg::STATUS_OK,       1'b0, 8'h00},
      '{MODE_BYTE, 8'h03, 1'b0, axfr_pkg::STATUS_OK,       1'b0, 8'h00},
      '{MODE_BYTE, 8'h03, 1'b1, axfr_pkg::STATUS_OK,       1'b0, 8'h03},
      '{MODE_BYTE, 8'h00, 1'b0, axfr_pkg::STATUS_OK,       1'b0, 8'h00},
      '{MODE_BYTE, 8'h00, 1'b0, axfr_pkg::STATUS_OK,       1'b0, 8'h00},
      '{MODE_BYTE, 8'h00, 1'b1, axfr_pkg::STATUS_OK,       1'b0, 8'h00},
      '{MODE_BYTE, 8'h80, 1'b0, axfr_pkg::STATUS_OK,       1'b0, 8'h00},
      '{MODE_BYTE, 8'h02, 1'b0, axfr_pkg::STATUS_OK,       1'b0, 8'h00},
      '{MODE_BYTE, 8'h00, 1'b1, axfr_pkg::STATUS_CSUM_ERR, 1'b1, 8'h00},
      '{MODE_BYTE, 8'h00, 1'b0, axfr_pkg::STATUS_OK,       1'b0, 8'h00},
      '{MODE_BYTE, 8'h25, 1'b1, axfr_pkg::STATUS_TOO_LONG, 1'b0, 8'h00},
      '{MODE_BYTE, 8'h00, 1'b0, axfr_pkg::STATUS_OK,       1'b0, 8'h00},
      '{MODE_BYTE, 8'h04, 1'b0, axfr_pkg::STATUS_OK,       1'b0, 8'h00},
      '{MODE_BYTE, 8'hFF, 1'b0, axfr_pkg::STATUS_OK,       1'b0, 8'h00},
      '{MODE_BYTE, 8'hFB, 1'b1, axfr_pkg::STATUS_OK,       1'b0, 8'hFF},
      '{MODE_BYTE, 8'h80, 1'b0, axfr_pkg::STATUS_OK,       1'b0, 8'h00},
      '{MODE_BYTE, 8'h06, 1'b0, axfr_pkg::STATUS_OK,       1'b0, 8'h00},
      '{MODE_BYTE, 8'h55, 1'b0, axfr_pkg::STATUS_OK,       1'b0, 8'h00},
      '{MODE_BYTE, 8'hAA, 1'b0, axfr_pkg::STATUS_OK,       1'b0, 8'h00},
      '{MODE_BYTE, 8'h01, 1'b0, axfr_pkg::STATUS_OK,       1'b0, 8'h00},
      '{MODE_BYTE, 8'h78, 1'b0, axfr_pkg::STATUS_OK,       1'b0, 8'h00}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (r = 0; r < DIR_ROWS; r++) begin
      send_item(directed_rows[r].mode, directed_rows[r].data);
      if (directed_rows[r].typed) begin
        if (model_out_count != 1) begin
          $error("directed row %0d: predictor gives %0d results", r, model_out_count);
          fail_count++;
        end else begin
          void'(expected_results.pop_back());
          typed_res = '{directed_rows[r].status, directed_rows[r].is_read,
                        directed_rows[r].command, 5'd0, 8'h00, 1'b0, 1'b1};
          expected_results.push_back(typed_res);
        end
      end
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      wait_drain();
      case (p)
        0: begin
          addr_val = 7'h7F;
          to_val = 16'd1;
        end
        1: begin
          addr_val = 7'h00;
          to_val = 16'hFFFF;
        end
        default: begin
          addr_val = 7'($urandom_range(0, 127));
          to_val = 16'($urandom_range(2, 4 * p));
        end
      endcase
      // upper bits of the address word are don't-care
      addr_word = 16'(($urandom_range(0, 511) << 7) | addr_val);
      write_reg(axfr_pkg::CFG_MY_ADDRESS, addr_word);
      write_reg(axfr_pkg::CFG_TIMEOUT_TICKS, to_val);
      cfg_valid <= 1'b0;
      fast_mode = (p == 1);
      hold_req = (p == 1);
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) begin
        kind = $urandom_range(0, 19);
        if (kind < 11) send_good_frame(1'b0);
        else if (kind < 13) send_good_frame(1'b1);
        else if (kind < 14) begin
          send_item(MODE_BYTE, {1'($urandom_range(0, 1)), my_addr});
          send_item(MODE_BYTE, 8'($urandom_range(PAYLOAD_MAX + 5, 255)));
        end else if (kind < 17) send_abort_frame();
        else repeat ($urandom_range(1, 4))
          send_item(1'($urandom_range(0, 1)), 8'($urandom));
      end
    end

    wait_drain();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
